FILE: rtl/u8cjk_pkg.sv
`default_nettype none

package u8cjk_pkg;

   localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

   localparam int unsigned CP_W  = 21;
   localparam int unsigned LEN_W = 3;

   localparam logic [CP_W-1:0] MARKER_CP = 21'h02581;

   localparam logic [CP_W-1:0] CJK_A_LO = 21'h04E00;
   localparam logic [CP_W-1:0] CJK_A_HI = 21'h09FFF;
   localparam logic [CP_W-1:0] CJK_B_LO = 21'h03400;
   localparam logic [CP_W-1:0] CJK_B_HI = 21'h04DBF;
   localparam logic [CP_W-1:0] CJK_C_LO = 21'h0F900;
   localparam logic [CP_W-1:0] CJK_C_HI = 21'h0FAFF;
   localparam logic [CP_W-1:0] CJK_D_LO = 21'h20000;
   localparam logic [CP_W-1:0] CJK_D_HI = 21'h2A6DF;

   localparam logic [1:0] CONT_TAG     = 2'b10;
   localparam logic [5:0] CONT_PAYLOAD = 6'h3F;

   // Results caused by one accepted byte: flushed held bytes, then an optional tail.
   typedef struct packed {
      logic [1:0]            held_n;
      logic [2:0][7:0]       held_bytes;
      logic                  has_tail;
      logic [CP_W-1:0]       tail_cp;
      logic [LEN_W-1:0]      tail_len;
      logic                  eot;
   } bundle_type;

   function automatic logic is_cjk(input logic [CP_W-1:0] cp);
      return ((cp >= CJK_A_LO) && (cp <= CJK_A_HI)) ||
             ((cp >= CJK_B_LO) && (cp <= CJK_B_HI)) ||
             ((cp >= CJK_C_LO) && (cp <= CJK_C_HI)) ||
             ((cp >= CJK_D_LO) && (cp <= CJK_D_HI));
   endfunction

endpackage

`default_nettype wire

FILE: rtl/u8cjk_if.sv
`default_nettype none

interface u8cjk_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       end_of_text;

   modport source (output valid, output text_byte, output end_of_text, input ready);
   modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface u8cjk_rsp_if;
   logic        valid;
   logic        ready;
   logic [20:0] code_point;
   logic [2:0]  byte_length;
   logic        cjk_flag;
   logic        marker_flag;
   logic        last_of_text;
   logic        expandable;

   modport source (output valid, output code_point, output byte_length, output cjk_flag,
                   output marker_flag, output last_of_text, output expandable,
                   input ready);
   modport sink   (input valid, input code_point, input byte_length, input cjk_flag,
                   input marker_flag, input last_of_text, input expandable,
                   output ready);
endinterface

`default_nettype wire

FILE: rtl/u8cjk_front.sv
`default_nettype none

module u8cjk_front (
   input  wire logic              clock,
   input  wire logic              reset,
   u8cjk_req_if.sink              req_if,
   input  wire logic              queue_full,
   output      logic              push,
   output      u8cjk_pkg::bundle_type push_data
);
   import u8cjk_pkg::*;

   logic [2:0]      exp_len_ff, exp_len_in;
   logic [CP_W-1:0] partial_ff, partial_in;
   logic [2:0][7:0] held_ff, held_in;
   logic [1:0]      held_cnt_ff, held_cnt_in;

   logic            accept;
   logic [7:0]      b;
   logic            eot;
   logic            is_open;
   logic            is_cont;
   logic [2:0]      f_len;
   logic [CP_W-1:0] f_bits;
   logic [CP_W-1:0] part;
   logic [2:0][7:0] held_ext;
   bundle_type      bun;

   assign req_if.ready = !queue_full;
   assign accept       = req_if.valid && !queue_full;
   assign b            = req_if.text_byte;
   assign eot          = req_if.end_of_text;
   assign is_open      = (exp_len_ff != 3'd0);
   assign is_cont      = (b[7:6] == CONT_TAG);
   assign part         = {partial_ff[CP_W-7:0], b[5:0] & CONT_PAYLOAD};

   always_comb begin
      priority if (b[7] == 1'b0) begin
         f_len  = 3'd1;
         f_bits = {13'd0, b};
      end else if (b[7:5] == 3'b110) begin
         f_len  = 3'd2;
         f_bits = {16'd0, b[4:0]};
      end else if (b[7:4] == 4'b1110) begin
         f_len  = 3'd3;
         f_bits = {17'd0, b[3:0]};
      end else if (b[7:3] == 5'b11110) begin
         f_len  = 3'd4;
         f_bits = {18'd0, b[2:0]};
      end else begin
         f_len  = 3'd1;
         f_bits = {13'd0, b};
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         held_ext[i] = (held_cnt_ff == 2'(i)) ? b : held_ff[i];
      end
   end

   always_comb begin
      bun         = '0;
      bun.eot     = eot;
      exp_len_in  = exp_len_ff;
      partial_in  = partial_ff;
      held_in     = held_ff;
      held_cnt_in = held_cnt_ff;

      if (is_open && is_cont) begin
         if (({1'b0, held_cnt_ff} + 3'd1) >= exp_len_ff) begin
            bun.has_tail = 1'b1;
            bun.tail_cp  = part;
            bun.tail_len = exp_len_ff;
            exp_len_in   = 3'd0;
            partial_in   = '0;
            held_cnt_in  = 2'd0;
         end else begin
            held_in     = held_ext;
            held_cnt_in = held_cnt_ff + 2'd1;
            partial_in  = part;
            if (eot) begin
               bun.held_bytes = held_ext;
               bun.held_n     = held_cnt_ff + 2'd1;
            end
         end
      end else begin
         if (is_open) begin
            bun.held_bytes = held_ff;
            bun.held_n     = held_cnt_ff;
            exp_len_in     = 3'd0;
            partial_in     = '0;
            held_cnt_in    = 2'd0;
         end
         if ((f_len == 3'd1) || eot) begin
            bun.has_tail = 1'b1;
            bun.tail_cp  = {13'd0, b};
            bun.tail_len = 3'd1;
         end else begin
            exp_len_in  = f_len;
            partial_in  = f_bits;
            held_in[0]  = b;
            held_cnt_in = 2'd1;
         end
      end

      if (eot) begin
         exp_len_in  = 3'd0;
         partial_in  = '0;
         held_cnt_in = 2'd0;
      end
   end

   assign push      = accept && (bun.has_tail || (bun.held_n != 2'd0));
   assign push_data = bun;

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_len_ff  <= 3'd0;
         partial_ff  <= '0;
         held_cnt_ff <= 2'd0;
      end else if (accept) begin
         exp_len_ff  <= exp_len_in;
         partial_ff  <= partial_in;
         held_cnt_ff <= held_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         held_ff <= held_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/u8cjk_queue.sv
`default_nettype none

module u8cjk_queue #(
   parameter int unsigned DEPTH = u8cjk_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire u8cjk_pkg::bundle_type push_data,
   output      logic                  full,
   input  wire logic                  pop,
   output      u8cjk_pkg::bundle_type head,
   output      logic                  empty
);
   import u8cjk_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   bundle_type       mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in;
   logic [PTR_W-1:0] rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_push;
   logic             do_pop;

   assign full    = (cnt_ff == CNT_W'(DEPTH));
   assign empty   = (cnt_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/u8cjk_back.sv
`default_nettype none

module u8cjk_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire u8cjk_pkg::bundle_type head,
   input  wire logic                  empty,
   output      logic                  pop,
   u8cjk_rsp_if.source                rsp_if
);
   import u8cjk_pkg::*;

   logic [1:0]       idx_ff, idx_in;
   logic [1:0]       cjk_cnt_ff, cjk_cnt_in;
   logic             non_cjk_ff, non_cjk_in;
   logic             valid_ff, valid_in;
   logic [CP_W-1:0]  cp_ff;
   logic [LEN_W-1:0] len_ff;
   logic             cjk_ff, mark_ff, last_ff, expand_ff;

   logic             advance;
   logic [2:0]       total;
   logic             elem_last;
   logic [7:0]       held_sel;
   logic [CP_W-1:0]  cp;
   logic [LEN_W-1:0] len;
   logic             cjk;
   logic             mark;
   logic [1:0]       cnt_new;
   logic             nc_new;
   logic             last;
   logic             expand;

   assign advance   = !empty && (!valid_ff || rsp_if.ready);
   assign total     = {1'b0, head.held_n} + {2'd0, head.has_tail};
   assign elem_last = ({1'b0, idx_ff} == (total - 3'd1));

   always_comb begin
      unique case (idx_ff)
         2'd0:    held_sel = head.held_bytes[0];
         2'd1:    held_sel = head.held_bytes[1];
         default: held_sel = head.held_bytes[2];
      endcase
   end

   always_comb begin
      if (idx_ff < head.held_n) begin
         cp  = {13'd0, held_sel};
         len = 3'd1;
      end else begin
         cp  = head.tail_cp;
         len = head.tail_len;
      end
   end

   assign cjk     = is_cjk(cp);
   assign mark    = (cp == MARKER_CP);
   assign cnt_new = (cjk && (cjk_cnt_ff != 2'd2)) ? cjk_cnt_ff + 2'd1 : cjk_cnt_ff;
   assign nc_new  = non_cjk_ff || (!cjk && !mark);
   assign last    = elem_last && head.eot;
   assign expand  = last && !nc_new && (cnt_new == 2'd2);
   assign pop     = advance && elem_last;

   always_comb begin
      idx_in     = idx_ff;
      cjk_cnt_in = cjk_cnt_ff;
      non_cjk_in = non_cjk_ff;
      valid_in   = rsp_if.ready ? 1'b0 : valid_ff;
      if (advance) begin
         valid_in   = 1'b1;
         idx_in     = elem_last ? 2'd0 : idx_ff + 2'd1;
         cjk_cnt_in = last ? 2'd0 : cnt_new;
         non_cjk_in = last ? 1'b0 : nc_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff     <= 2'd0;
         cjk_cnt_ff <= 2'd0;
         non_cjk_ff <= 1'b0;
         valid_ff   <= 1'b0;
      end else begin
         idx_ff     <= idx_in;
         cjk_cnt_ff <= cjk_cnt_in;
         non_cjk_ff <= non_cjk_in;
         valid_ff   <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         cp_ff     <= cp;
         len_ff    <= len;
         cjk_ff    <= cjk;
         mark_ff   <= mark;
         last_ff   <= last;
         expand_ff <= expand;
      end
   end

   assign rsp_if.valid        = valid_ff;
   assign rsp_if.code_point   = cp_ff;
   assign rsp_if.byte_length  = len_ff;
   assign rsp_if.cjk_flag     = cjk_ff;
   assign rsp_if.marker_flag  = mark_ff;
   assign rsp_if.last_of_text = last_ff;
   assign rsp_if.expandable   = expand_ff;

endmodule

`default_nettype wire

FILE: rtl/utf8_decode_cjk_classify_core.sv
// UTF-8 decoder with CJK classification. Takes one byte of text per cycle on
// req_if while the queue has room and returns one decoded code point per cycle
// on rsp_if while ready allows, flagged as CJK (U+3400..4DBF, U+4E00..9FFF,
// U+F900..FAFF, U+20000..2A6DF) or as the U+2581 marker; the last result of a
// text carries last_of_text and the expandable verdict. No overlong check;
// broken or truncated sequences come out byte by byte. The front decoder takes
// a byte every cycle, stalling only when the queue is full, and writes the
// results it causes (up to four; a byte that causes none writes nothing) as one
// entry into a queue of QUEUE_DEPTH entries; the back end drains one result per
// cycle into the output register unless ready stalls it, so a byte's results
// leave in turn. A result is registered in the queue, then the output register.
`default_nettype none

module utf8_decode_cjk_classify_core #(
   parameter int unsigned QUEUE_DEPTH = u8cjk_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic   clock,
   input  wire logic   reset,
   u8cjk_req_if.sink   req_if,
   u8cjk_rsp_if.source rsp_if
);
   import u8cjk_pkg::*;

   logic       push;
   bundle_type push_data;
   logic       full;
   logic       pop;
   bundle_type head;
   logic       empty;

   u8cjk_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .queue_full (full),
      .push       (push),
      .push_data  (push_data)
   );

   u8cjk_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .head      (head),
      .empty     (empty)
   );

   u8cjk_back u_back (
      .clock  (clock),
      .reset  (reset),
      .head   (head),
      .empty  (empty),
      .pop    (pop),
      .rsp_if (rsp_if)
   );

endmodule

`default_nettype wire
